/* sv/llg_pkg.sv */
`default_nettype none
package llg_pkg;

	localparam int ATOMS = 1024;
	localparam int ADDR_W = $clog2(ATOMS);

	localparam int IDX_W = 10;
	localparam int SPIN_W = 16;
	localparam int FIELD_W = 32;
	localparam int GAIN_W = 32;
	localparam int INC_W = 24;
	localparam int V_W = 26;        // spin plus increment in Q1.22, with headroom
	localparam int MAG_W = 25;      // magnitude of a V_W value
	localparam int SQ_W = 50;       // sum of three squares
	localparam int ROOT_W = 25;
	localparam int SQRT_STEPS = 25; // one root bit per stage
	localparam int QUO_W = 15;      // quotient never exceeds 2^14
	localparam int NUM_W = 40;      // |v| << 14 plus half the root

	localparam int INC_LAT = 5;
	localparam int NORM_LAT = 44;

	localparam logic MODE_PREDICT = 1'b0;
	localparam logic MODE_CORRECT = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PRECESSION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 1'b1;

	typedef logic signed [SPIN_W-1:0] spin_t;
	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic signed [INC_W-1:0] inc_t;
	typedef logic signed [V_W-1:0] vec_t;

	localparam inc_t INC_MAX = 24'sh7FFFFF;
	localparam inc_t INC_MIN = 24'sh800000;
	localparam logic [QUO_W-1:0] UNIT = 15'd16384;

	typedef struct packed {
		logic mode;
		logic [IDX_W-1:0] atom_index;
		spin_t spin_x;
		spin_t spin_y;
		spin_t spin_z;
		field_t field_x;
		field_t field_y;
		field_t field_z;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		spin_t new_x;
		spin_t new_y;
		spin_t new_z;
		logic zero_norm;
	} result_t;

endpackage
`default_nettype wire

/* sv/llg_heun_spin_step.sv */
`default_nettype none
// Channel  Dir  Handshake                  Payload
// item     in   item_valid / item_ready    item_t: mode, atom_index, spin, field
// result   out  result_valid / result_ready result_t: out_index, new spin, zero_norm
// cfg      in   cfg_valid / cfg_ready      cfg_index, cfg_data (gain registers)
//
// One item per cycle while item_ready is high. An item passes through the
// input register, 5 increment stages, sum stage, 44 normalize stages
// (25 root steps, 15 divide steps) and the result register.
// A correct item whose atom still has a predict in flight is held off until
// that predict writes the atom store at the pipeline end.
// Reset clears valid bits and both gains; the atom store is not cleared.
// A held result freezes the whole pipeline; nothing is dropped or repeated.
module llg_heun_spin_step import llg_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input item_t item,
	output logic result_valid,
	input logic result_ready,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input gain_t cfg_data
);

	localparam int V_STAGE = 2 + INC_LAT;
	localparam int PIPE_DEPTH = V_STAGE + NORM_LAT;

	// per-atom store word: start spin, predicted spin, first increment
	typedef struct packed {
		logic [2:0][SPIN_W-1:0] s0;
		logic [2:0][SPIN_W-1:0] sp;
		logic [2:0][INC_W-1:0] inc;
	} store_t;

	// sideband that rides with each item
	typedef struct packed {
		logic corr;
		logic wr;
		logic [IDX_W-1:0] idx;
		logic [2:0][SPIN_W-1:0] s0;
		logic [2:0][INC_W-1:0] inc;
	} side_t;

	gain_t prec_gain_q;
	gain_t damp_gain_q;

	logic adv;
	logic take;
	logic hit;
	logic ok_in;

	logic [PIPE_DEPTH:1] vld_s;
	item_t item_s1;
	logic ok_s1;
	logic corr_s1;
	logic wr_s1;

	store_t rd;
	store_t wdata;
	logic we;

	spin_t spin_in [3];
	field_t field_in [3];
	spin_t s0_c [3];
	spin_t sp_c [3];
	inc_t i1_c [3];

	side_t side_s [2:PIPE_DEPTH];
	inc_t inc_o [3];
	logic signed [INC_W:0] isum [3];
	inc_t avg [3];
	vec_t v_s7 [3];

	spin_t norm_o [3];
	logic norm_zero;

	logic res_vld_q;
	result_t res_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_gain_q <= '0;
			damp_gain_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PRECESSION: prec_gain_q <= cfg_data;
				REG_DAMPING: damp_gain_q <= cfg_data;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// Everything moves together; the result register is the only holding point.
	assign adv = !res_vld_q || result_ready;
	assign ok_in = 32'(item.atom_index) < ATOMS;
	assign corr_s1 = (item_s1.mode == MODE_CORRECT);
	assign wr_s1 = (item_s1.mode == MODE_PREDICT) && ok_s1;

	// read-after-write guard on the atom store
	always_comb begin
		hit = vld_s[1] && wr_s1 && (item_s1.atom_index == item.atom_index);
		for (int k = 2; k <= PIPE_DEPTH; k++) begin
			if (vld_s[k] && side_s[k].wr && (side_s[k].idx == item.atom_index)) begin
				hit = 1'b1;
			end
		end
	end

	assign item_ready = adv && !((item.mode == MODE_CORRECT) && hit);
	assign take = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-1:1], take};
			res_vld_q <= vld_s[PIPE_DEPTH];
		end
	end

	// ---------------- stage 1: input register, store read ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			ok_s1 <= ok_in;
		end
	end

	llg_ram #(
		.WIDTH($bits(store_t)),
		.DEPTH(ATOMS)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(ADDR_W'(side_s[PIPE_DEPTH].idx)),
		.wdata(wdata),
		.re(adv),
		.raddr(ADDR_W'(item.atom_index)),
		.rdata(rd)
	);

	assign spin_in[0] = item_s1.spin_x;
	assign spin_in[1] = item_s1.spin_y;
	assign spin_in[2] = item_s1.spin_z;
	assign field_in[0] = item_s1.field_x;
	assign field_in[1] = item_s1.field_y;
	assign field_in[2] = item_s1.field_z;

	// correct items take spins and first increment from the store
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!corr_s1) begin
				s0_c[k] = spin_in[k];
				sp_c[k] = spin_in[k];
				i1_c[k] = '0;
			end else if (ok_s1) begin
				s0_c[k] = spin_t'(rd.s0[k]);
				sp_c[k] = spin_t'(rd.sp[k]);
				i1_c[k] = inc_t'(rd.inc[k]);
			end else begin
				s0_c[k] = '0;
				sp_c[k] = '0;
				i1_c[k] = '0;
			end
		end
	end

	// ---------------- stages 2..6: increment ----------------
	llg_incr u_incr (
		.clk(clk),
		.en(adv),
		.spin(sp_c),
		.field(field_in),
		.prec_gain(prec_gain_q),
		.damp_gain(damp_gain_q),
		.inc(inc_o)
	);

	// sideband line; from the sum stage on it carries this item's increment
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[2].corr <= corr_s1;
			side_s[2].wr <= wr_s1;
			side_s[2].idx <= item_s1.atom_index;
			for (int k = 0; k < 3; k++) begin
				side_s[2].s0[k] <= s0_c[k];
				side_s[2].inc[k] <= i1_c[k];
			end
			for (int k = 3; k <= PIPE_DEPTH; k++) begin
				if (k == V_STAGE) begin
					side_s[k].corr <= side_s[k-1].corr;
					side_s[k].wr <= side_s[k-1].wr;
					side_s[k].idx <= side_s[k-1].idx;
					side_s[k].s0 <= side_s[k-1].s0;
					for (int c = 0; c < 3; c++) begin
						side_s[k].inc[c] <= inc_o[c];
					end
				end else begin
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	// ---------------- stage 7: Heun sum ----------------
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			isum[k] = (INC_W+1)'(inc_t'(side_s[V_STAGE-1].inc[k])) + (INC_W+1)'(inc_o[k]);
			avg[k] = isum[k][INC_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				v_s7[k] <= (V_W'(spin_t'(side_s[V_STAGE-1].s0[k])) <<< 8)
					+ (side_s[V_STAGE-1].corr ? V_W'(avg[k]) : V_W'(inc_o[k]));
			end
		end
	end

	// ---------------- stages 8..51: normalize ----------------
	llg_norm u_norm (
		.clk(clk),
		.en(adv),
		.v(v_s7),
		.o(norm_o),
		.zero(norm_zero)
	);

	// ---------------- store write and result register ----------------
	assign we = adv && vld_s[PIPE_DEPTH] && side_s[PIPE_DEPTH].wr;

	always_comb begin
		wdata.s0 = side_s[PIPE_DEPTH].s0;
		wdata.inc = side_s[PIPE_DEPTH].inc;
		for (int k = 0; k < 3; k++) begin
			wdata.sp[k] = norm_o[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_index <= side_s[PIPE_DEPTH].idx;
			res_q.new_x <= norm_o[0];
			res_q.new_y <= norm_o[1];
			res_q.new_z <= norm_o[2];
			res_q.zero_norm <= norm_zero;
		end
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

endmodule
`default_nettype wire

/* sv/llg_ram.sv */
`default_nettype none
module llg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/llg_incr.sv */
`default_nettype none
// dS = g1 * (S x H) + g2 * (S x (S x H)), five register stages.
module llg_incr import llg_pkg::*; (
	input logic clk,
	input logic en,
	input spin_t spin [3],
	input field_t field [3],
	input gain_t prec_gain,
	input gain_t damp_gain,
	output inc_t inc [3]
);

	// pair order: xx yy zz xy xz yz
	logic signed [31:0] pp [6];
	logic signed [47:0] cp [6];
	logic signed [17:0] pr_s2 [6];
	logic signed [47:0] cp_s2 [6];
	field_t h_s2 [3];

	logic signed [18:0] qs [3];
	logic signed [50:0] dp [9];
	logic signed [48:0] c_s3 [3];
	logic signed [50:0] dp_s3 [9];

	logic signed [52:0] dd [3];
	logic signed [29:0] csh_s4 [3];
	logic signed [33:0] dsh_s4 [3];

	logic signed [61:0] t1_s5 [3];
	logic signed [65:0] t2_s5 [3];

	logic signed [66:0] tt [3];
	logic signed [45:0] ts [3];
	inc_t inc_s6 [3];

	always_comb begin
		pp[0] = spin[0] * spin[0];
		pp[1] = spin[1] * spin[1];
		pp[2] = spin[2] * spin[2];
		pp[3] = spin[0] * spin[1];
		pp[4] = spin[0] * spin[2];
		pp[5] = spin[1] * spin[2];
		cp[0] = spin[1] * field[2];
		cp[1] = spin[2] * field[1];
		cp[2] = spin[2] * field[0];
		cp[3] = spin[0] * field[2];
		cp[4] = spin[0] * field[1];
		cp[5] = spin[1] * field[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) begin
				pr_s2[i] <= pp[i][31:14];
				cp_s2[i] <= cp[i];
			end
			for (int k = 0; k < 3; k++) begin
				h_s2[k] <= field[k];
			end
		end
	end

	// S(S.H) - H(S.S), grouped by field component
	always_comb begin
		qs[0] = 19'(pr_s2[1]) + 19'(pr_s2[2]);
		qs[1] = 19'(pr_s2[0]) + 19'(pr_s2[2]);
		qs[2] = 19'(pr_s2[0]) + 19'(pr_s2[1]);
		dp[0] = 51'(pr_s2[3]) * 51'(h_s2[1]);
		dp[1] = 51'(pr_s2[4]) * 51'(h_s2[2]);
		dp[2] = 51'(qs[0]) * 51'(h_s2[0]);
		dp[3] = 51'(pr_s2[3]) * 51'(h_s2[0]);
		dp[4] = 51'(pr_s2[5]) * 51'(h_s2[2]);
		dp[5] = 51'(qs[1]) * 51'(h_s2[1]);
		dp[6] = 51'(pr_s2[4]) * 51'(h_s2[0]);
		dp[7] = 51'(pr_s2[5]) * 51'(h_s2[1]);
		dp[8] = 51'(qs[2]) * 51'(h_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3[0] <= 49'(cp_s2[0]) - 49'(cp_s2[1]);
			c_s3[1] <= 49'(cp_s2[2]) - 49'(cp_s2[3]);
			c_s3[2] <= 49'(cp_s2[4]) - 49'(cp_s2[5]);
			for (int i = 0; i < 9; i++) begin
				dp_s3[i] <= dp[i];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dd[k] = 53'(dp_s3[3*k]) + 53'(dp_s3[3*k+1]) - 53'(dp_s3[3*k+2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				csh_s4[k] <= c_s3[k][48:19];
				dsh_s4[k] <= dd[k][52:19];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t1_s5[k] <= 62'(csh_s4[k]) * 62'(prec_gain);
				t2_s5[k] <= 66'(dsh_s4[k]) * 66'(damp_gain);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tt[k] = 67'(t1_s5[k]) + 67'(t2_s5[k]);
			ts[k] = tt[k][66:21];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (ts[k] > 46'(INC_MAX)) begin
					inc_s6[k] <= INC_MAX;
				end else if (ts[k] < 46'(INC_MIN)) begin
					inc_s6[k] <= INC_MIN;
				end else begin
					inc_s6[k] <= ts[k][INC_W-1:0];
				end
			end
		end
	end

	assign inc = inc_s6;

endmodule
`default_nettype wire

/* sv/llg_norm.sv */
`default_nettype none
// v / |v| with one shared root: squares, sum, bitwise root, restoring divide.
module llg_norm import llg_pkg::*; (
	input logic clk,
	input logic en,
	input vec_t v [3],
	output spin_t o [3],
	output logic zero
);

	localparam int RW = SQ_W + 1;
	localparam int LAST = SQRT_STEPS - 1;
	localparam int DLAST = QUO_W - 1;

	logic signed [51:0] vv [3];
	logic [SQ_W-1:0] sq_s1 [3];
	vec_t v_s1 [3];
	logic [SQ_W-1:0] n2_s2;
	vec_t v_s2 [3];

	logic [SQ_W-1:0] rem_s [SQRT_STEPS];
	logic [RW-1:0] root_s [SQRT_STEPS];
	vec_t vq_s [SQRT_STEPS][3];

	logic [ROOT_W-1:0] rt;
	logic [V_W-1:0] mag [3];
	logic [NUM_W-1:0] num_s28 [3];
	logic [ROOT_W-1:0] r_s28;
	logic neg_s28 [3];
	logic zero_s28;

	logic [NUM_W-1:0] drem_s [QUO_W][3];
	logic [QUO_W-1:0] quo_s [QUO_W][3];
	logic [ROOT_W-1:0] dr_s [QUO_W];
	logic dneg_s [QUO_W][3];
	logic dzero_s [QUO_W];

	logic [QUO_W-1:0] qc [3];
	spin_t o_s44 [3];
	logic zero_s44;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vv[k] = 52'(v[k]) * 52'(v[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= vv[k][SQ_W-1:0];
				v_s1[k] <= v[k];
			end
			n2_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			v_s2 <= v_s1;
		end
	end

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam int SH = 2 * (SQRT_STEPS - 1 - j);
		localparam logic [RW-1:0] BIT = RW'(1) << SH;
		logic [SQ_W-1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [RW-1:0] trial;
		vec_t v_in [3];

		if (j == 0) begin : g_head
			assign rem_in = n2_s2;
			assign root_in = '0;
			assign v_in = v_s2;
		end else begin : g_body
			assign rem_in = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign v_in = vq_s[j-1];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_in} >= trial) begin
					rem_s[j] <= rem_in - trial[SQ_W-1:0];
					root_s[j] <= (root_in >> 1) + BIT;
				end else begin
					rem_s[j] <= rem_in;
					root_s[j] <= root_in >> 1;
				end
				vq_s[j] <= v_in;
			end
		end
	end

	assign rt = root_s[LAST][ROOT_W-1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = vq_s[LAST][k][V_W-1] ? V_W'(-vq_s[LAST][k]) : V_W'(vq_s[LAST][k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				num_s28[k] <= (NUM_W'(mag[k][MAG_W-1:0]) << 14) + NUM_W'(rt >> 1);
				neg_s28[k] <= vq_s[LAST][k][V_W-1];
			end
			r_s28 <= rt;
			zero_s28 <= (rt == '0);
		end
	end

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		localparam int B = QUO_W - 1 - i;
		logic [NUM_W-1:0] rem_in [3];
		logic [QUO_W-1:0] quo_in [3];
		logic [ROOT_W-1:0] r_in;
		logic neg_in [3];
		logic zero_in;
		logic [NUM_W-1:0] dv;

		if (i == 0) begin : g_head
			assign rem_in = num_s28;
			assign quo_in = '{default: '0};
			assign r_in = r_s28;
			assign neg_in = neg_s28;
			assign zero_in = zero_s28;
		end else begin : g_body
			assign rem_in = drem_s[i-1];
			assign quo_in = quo_s[i-1];
			assign r_in = dr_s[i-1];
			assign neg_in = dneg_s[i-1];
			assign zero_in = dzero_s[i-1];
		end

		assign dv = NUM_W'(r_in) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					if (rem_in[k] >= dv) begin
						drem_s[i][k] <= rem_in[k] - dv;
						quo_s[i][k] <= {quo_in[k][QUO_W-2:0], 1'b1};
					end else begin
						drem_s[i][k] <= rem_in[k];
						quo_s[i][k] <= {quo_in[k][QUO_W-2:0], 1'b0};
					end
				end
				dr_s[i] <= r_in;
				dneg_s[i] <= neg_in;
				dzero_s[i] <= zero_in;
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qc[k] = (quo_s[DLAST][k] > UNIT) ? UNIT : quo_s[DLAST][k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (dzero_s[DLAST]) begin
					o_s44[k] <= '0;
				end else if (dneg_s[DLAST][k]) begin
					o_s44[k] <= -spin_t'({1'b0, qc[k]});
				end else begin
					o_s44[k] <= spin_t'({1'b0, qc[k]});
				end
			end
			zero_s44 <= dzero_s[DLAST];
		end
	end

	assign o = o_s44;
	assign zero = zero_s44;

endmodule
`default_nettype wire
